/* hdl/weighted_overlap_add_synthesis_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for weighted overlap-add synthesis
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_OVERLAP_ADD_SYNTHESIS_MACROS_SVH
`define WEIGHTED_OVERLAP_ADD_SYNTHESIS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define WOLA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WOLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wola_pkg.sv */
// ----------------------------------------------------------------------------
// wola_pkg
// Shared constants, state types and divider interface structs.
// ----------------------------------------------------------------------------
package wola_pkg;

  // Default geometry
  localparam int unsigned FRAME_LEN_DEF = 512;
  localparam int unsigned HOP_LEN_DEF   = 256;

  // Fixed field and accumulator widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned QUO_W    = 16;

  // pi in Q30, used for the window build
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Main sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_PUSH
  } state_e;

  // Divider states
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_PREP,
    DV_CHECK,
    DV_ITER,
    DV_DONE
  } div_state_e;

  // Divider request: overlap sum over envelope sum
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] overlap;
    logic        [ACC_W-1:0] envelope;
  } div_req_t;

  // Divider status and normalised, saturated result
  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic signed [SAMPLE_W-1:0] result;
  } div_rsp_t;

endpackage

/* hdl/wola_window_rom.sv */
// ----------------------------------------------------------------------------
// wola_window_rom
// Square-root Hann coefficient ROM, Q1.15, registered read.
// ----------------------------------------------------------------------------
module wola_window_rom #(
  parameter int unsigned FRAME_LEN = wola_pkg::FRAME_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(FRAME_LEN)-1:0] rd_addr_i,
  output logic [wola_pkg::SAMPLE_W-1:0] rd_data_o
);

  typedef logic [wola_pkg::SAMPLE_W-1:0] coef_arr_t [FRAME_LEN];

  // sin(pi*i/N) in Q30 by a Taylor series on the folded angle, rounded to Q15
  function automatic logic [wola_pkg::SAMPLE_W-1:0] sine_q15(input int unsigned i);
    logic        [63:0] f;
    logic        [63:0] x;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] r;
    f    = (i <= FRAME_LEN / 2) ? 64'(i) : 64'(FRAME_LEN - i);
    x    = (wola_pkg::PI_Q30 * f) / FRAME_LEN;
    term = x;
    sum  = $signed(x);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 6;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 20;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 42;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 72;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return 16'(r);
  endfunction

  function automatic coef_arr_t build_table();
    coef_arr_t t;
    for (int unsigned i = 0; i < FRAME_LEN; i++) begin
      t[i] = sine_q15(i);
    end
    return t;
  endfunction

  localparam coef_arr_t COEF_ROM = build_table();

  logic [wola_pkg::SAMPLE_W-1:0] rd_data_q;

  // Synchronous read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= COEF_ROM[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/wola_store.sv */
// ----------------------------------------------------------------------------
// wola_store
// Overlap and envelope accumulator memories, one write and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module wola_store #(
  parameter int unsigned FRAME_LEN = wola_pkg::FRAME_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(FRAME_LEN)-1:0]        rd_addr_i,
  output logic signed [wola_pkg::ACC_W-1:0]   rd_overlap_o,
  output logic        [wola_pkg::ACC_W-1:0]   rd_envelope_o,
  input  logic                                wr_en_i,
  input  logic [$clog2(FRAME_LEN)-1:0]        wr_addr_i,
  input  logic signed [wola_pkg::ACC_W-1:0]   wr_overlap_i,
  input  logic        [wola_pkg::ACC_W-1:0]   wr_envelope_i
);

  logic signed [wola_pkg::ACC_W-1:0] ovl_mem [FRAME_LEN];
  logic        [wola_pkg::ACC_W-1:0] env_mem [FRAME_LEN];

  logic signed [wola_pkg::ACC_W-1:0] rd_ovl_q;
  logic        [wola_pkg::ACC_W-1:0] rd_env_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ovl_mem[wr_addr_i] <= wr_overlap_i;
      env_mem[wr_addr_i] <= wr_envelope_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_ovl_q <= ovl_mem[rd_addr_i];
      rd_env_q <= env_mem[rd_addr_i];
    end
  end

  assign rd_overlap_o  = rd_ovl_q;
  assign rd_envelope_o = rd_env_q;

endmodule

/* hdl/wola_divider.sv */
// ----------------------------------------------------------------------------
// wola_divider
// Restoring divider: round(overlap * 2^15 / envelope), halves away from
// zero, saturated to Q1.15. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module wola_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wola_pkg::div_req_t req_i,
  output wola_pkg::div_rsp_t rsp_o
);

  localparam int unsigned AW = wola_pkg::ACC_W;
  localparam int unsigned QW = wola_pkg::QUO_W;
  localparam int unsigned NW = 64;

  wola_pkg::div_state_e state_q, state_d;

  logic signed [AW-1:0] ovl_q;
  logic        [AW-1:0] env_q;
  logic                 neg_q;
  logic        [NW-1:0] num_q;
  logic        [AW-1:0] den_q;
  logic        [AW-1:0] rem_q;
  logic        [QW-1:0] quo_q;
  logic   [$clog2(QW)-1:0] bit_q;
  logic                 ovf_q;
  logic        [QW-1:0] res_q;
  logic                 done_q;

  logic        [AW-1:0] mag;
  logic        [AW-1:0] den_floor;
  logic        [QW-1:0] num_lo;
  logic        [AW:0]   trial;
  logic                 trial_ge;
  logic        [QW-1:0] sat_res;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wola_pkg::DV_IDLE:  if (req_i.start) state_d = wola_pkg::DV_PREP;
      wola_pkg::DV_PREP:  state_d = wola_pkg::DV_CHECK;
      wola_pkg::DV_CHECK: begin
        state_d = (num_q >= {den_q, {QW{1'b0}}}) ? wola_pkg::DV_DONE : wola_pkg::DV_ITER;
      end
      wola_pkg::DV_ITER:  if (bit_q == '0) state_d = wola_pkg::DV_DONE;
      wola_pkg::DV_DONE:  state_d = wola_pkg::DV_IDLE;
      default:            state_d = wola_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wola_pkg::DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == wola_pkg::DV_DONE);
    end
  end

  // Magnitude, floored divisor, one trial subtraction per cycle
  assign mag       = ovl_q[AW-1] ? AW'(-ovl_q) : AW'(ovl_q);
  assign den_floor = (env_q == '0) ? AW'(1) : env_q;
  assign num_lo    = num_q[QW-1:0];
  assign trial     = {rem_q, num_lo[bit_q]};
  assign trial_ge  = trial >= {1'b0, den_q};

  // Saturate to Q1.15; the magnitude reaches 2^15 only on the negative side
  always_comb begin
    if (neg_q) begin
      sat_res = (ovf_q || quo_q > QW'(32768)) ? QW'(32768) : QW'(-quo_q);
    end else begin
      sat_res = (ovf_q || quo_q > QW'(32767)) ? QW'(32767) : quo_q;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      wola_pkg::DV_IDLE: begin
        if (req_i.start) begin
          ovl_q <= req_i.overlap;
          env_q <= req_i.envelope;
        end
      end
      wola_pkg::DV_PREP: begin
        neg_q <= ovl_q[AW-1];
        den_q <= den_floor;
        num_q <= {1'b0, mag, 15'b0} + NW'(den_floor[AW-1:1]);
      end
      wola_pkg::DV_CHECK: begin
        ovf_q <= num_q >= {den_q, {QW{1'b0}}};
        rem_q <= num_q[NW-1:QW];
        quo_q <= '0;
        bit_q <= '1;
      end
      wola_pkg::DV_ITER: begin
        rem_q        <= trial_ge ? AW'(trial - {1'b0, den_q}) : trial[AW-1:0];
        quo_q[bit_q] <= trial_ge;
        bit_q        <= bit_q - 1'b1;
      end
      wola_pkg::DV_DONE: begin
        res_q <= sat_res;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.busy   = (state_q != wola_pkg::DV_IDLE);
  assign rsp_o.done   = done_q;
  assign rsp_o.result = $signed(res_q);

endmodule

/* hdl/weighted_overlap_add_synthesis.sv */
// ----------------------------------------------------------------------------
// weighted_overlap_add_synthesis
// Windowed overlap-add with window-envelope normalisation, Q1.15 in and out.
// ----------------------------------------------------------------------------
// Each input beat is either a frame sample (kind 0, FRAME_LEN per frame, in
// order) or a drain request (kind 1). A frame sample is weighted by a
// square-root Hann coefficient and read-modify-written into the overlap and
// envelope memories; positions below HOP_LEN from the second frame on give
// one output beat of overlap/envelope, rounded and saturated. Drain beats
// read out the FRAME_LEN-HOP_LEN pending tail, flagging the last one. Items
// are handled one at a time: a beat that gives a result goes through the
// 16-step restoring divider (cut short when the quotient overflows and
// saturates straight away) and then waits for the output register to be
// free; drain requests before the first full frame give no output. The
// last sample of each frame is followed by a sweep that clears
// min(HOP_LEN, FRAME_LEN) memory entries as the ring advances. After reset
// the block clears all FRAME_LEN entries of both memories before in_ready_o
// first rises. A result waits in the output register while the next beat
// is taken.
// ----------------------------------------------------------------------------
`include "weighted_overlap_add_synthesis_macros.svh"

module weighted_overlap_add_synthesis #(
  parameter int unsigned FRAME_LEN = wola_pkg::FRAME_LEN_DEF,
  parameter int unsigned HOP_LEN   = wola_pkg::HOP_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic signed [wola_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wola_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                is_tail_o,
  output logic                                tail_last_o
);

  localparam int unsigned AW       = $clog2(FRAME_LEN);
  localparam int unsigned CW       = $clog2(FRAME_LEN + 1);
  localparam int unsigned DW       = wola_pkg::ACC_W;
  localparam int unsigned SW       = wola_pkg::SAMPLE_W;
  localparam int unsigned TAIL_LEN = (FRAME_LEN > HOP_LEN) ? FRAME_LEN - HOP_LEN : 0;
  localparam int unsigned CLR_LEN  = (HOP_LEN < FRAME_LEN) ? HOP_LEN : FRAME_LEN;
  localparam int unsigned HOP_STEP = HOP_LEN % FRAME_LEN;
  localparam bit          HAS_TAIL = (TAIL_LEN != 0);
  localparam bit          ALL_OUT  = (HOP_LEN >= FRAME_LEN);
  localparam logic [AW:0] FL_W     = (AW + 1)'(FRAME_LEN);

  wola_pkg::state_e state_q, state_d;

  // Sequencer state
  logic [AW-1:0] fp_q, rb_q, dp_q;
  logic          seen_q;
  logic [AW-1:0] clr_addr_q;
  logic [CW-1:0] clr_left_q;

  // Item in flight
  logic          kind_q;
  logic signed [SW-1:0] sample_q;
  logic [AW-1:0] idx_q;
  logic          want_out_q;
  logic          frame_end_q;
  logic          last_q;
  logic signed [2*SW:0]   prod_ovl_q;
  logic        [2*SW-1:0] prod_env_q;

  // Output register
  logic          out_valid_q;
  logic signed [SW-1:0] out_sample_q;
  logic          is_tail_q;
  logic          tail_last_q;

  // Combinational
  logic          accept;
  logic          drain_ok;
  logic [AW-1:0] pos;
  logic [AW:0]   idx_sum;
  logic [AW-1:0] idx;
  logic [AW:0]   rb_sum;
  logic [AW-1:0] rb_next;
  logic          frame_want;
  logic          drain_last;
  logic          out_free;

  logic                 st_rd_en, st_wr_en;
  logic [AW-1:0]        st_wr_addr;
  logic signed [DW-1:0] st_rd_ovl, st_wr_ovl, sum_ovl;
  logic        [DW-1:0] st_rd_env, st_wr_env, sum_env;
  logic [SW-1:0]        win;

  wola_pkg::div_req_t div_req;
  wola_pkg::div_rsp_t div_rsp;

  // Handshake and address arithmetic
  assign in_ready_o = (state_q == wola_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign drain_ok   = seen_q && HAS_TAIL;
  assign pos        = kind_i ? dp_q : fp_q;
  assign idx_sum    = {1'b0, rb_q} + {1'b0, pos};
  assign idx        = (idx_sum >= FL_W) ? AW'(idx_sum - FL_W) : idx_sum[AW-1:0];
  assign rb_sum     = {1'b0, rb_q} + (AW + 1)'(HOP_STEP);
  assign rb_next    = (rb_sum >= FL_W) ? AW'(rb_sum - FL_W) : rb_sum[AW-1:0];
  assign frame_want = seen_q && (ALL_OUT || fp_q < AW'(HOP_LEN));
  assign drain_last = (dp_q == AW'(TAIL_LEN - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // Accumulate: signed product extends, squared weight zero-extends
  assign sum_ovl = st_rd_ovl + DW'(prod_ovl_q);
  assign sum_env = st_rd_env + DW'(prod_env_q);

  // Memory ports: one read at accept, writes in accumulate and clear only
  assign st_rd_en   = accept && (!kind_i || drain_ok);
  assign st_wr_en   = (state_q == wola_pkg::ST_CLEAR) ||
                      ((state_q == wola_pkg::ST_ACC) && !kind_q);
  assign st_wr_addr = (state_q == wola_pkg::ST_CLEAR) ? clr_addr_q : idx_q;
  assign st_wr_ovl  = (state_q == wola_pkg::ST_CLEAR) ? '0 : sum_ovl;
  assign st_wr_env  = (state_q == wola_pkg::ST_CLEAR) ? '0 : sum_env;

  // Divider request from the freshly accumulated (or drained) entry
  assign div_req.start    = (state_q == wola_pkg::ST_ACC) && want_out_q;
  assign div_req.overlap  = kind_q ? st_rd_ovl : sum_ovl;
  assign div_req.envelope = kind_q ? st_rd_env : sum_env;

  wola_window_rom #(
    .FRAME_LEN (FRAME_LEN)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (accept && !kind_i),
    .rd_addr_i (fp_q),
    .rd_data_o (win)
  );

  wola_store #(
    .FRAME_LEN (FRAME_LEN)
  ) u_store (
    .clk_i         (clk_i),
    .rd_en_i       (st_rd_en),
    .rd_addr_i     (idx),
    .rd_overlap_o  (st_rd_ovl),
    .rd_envelope_o (st_rd_env),
    .wr_en_i       (st_wr_en),
    .wr_addr_i     (st_wr_addr),
    .wr_overlap_i  (st_wr_ovl),
    .wr_envelope_i (st_wr_env)
  );

  wola_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wola_pkg::ST_CLEAR: begin
        if (clr_left_q == CW'(1)) state_d = wola_pkg::ST_IDLE;
      end
      wola_pkg::ST_IDLE: begin
        if (accept && (!kind_i || drain_ok)) state_d = wola_pkg::ST_MUL;
      end
      wola_pkg::ST_MUL: state_d = wola_pkg::ST_ACC;
      wola_pkg::ST_ACC: begin
        if (want_out_q)       state_d = wola_pkg::ST_DIV;
        else if (frame_end_q) state_d = wola_pkg::ST_CLEAR;
        else                  state_d = wola_pkg::ST_IDLE;
      end
      wola_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = wola_pkg::ST_PUSH;
      end
      wola_pkg::ST_PUSH: begin
        if (out_free) state_d = frame_end_q ? wola_pkg::ST_CLEAR : wola_pkg::ST_IDLE;
      end
      default: state_d = wola_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wola_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Ring position, drain position and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q       <= '0;
      rb_q       <= '0;
      dp_q       <= '0;
      seen_q     <= 1'b0;
      clr_addr_q <= '0;
      clr_left_q <= CW'(FRAME_LEN);
    end else begin
      if (state_q == wola_pkg::ST_CLEAR) begin
        clr_addr_q <= (clr_addr_q == AW'(FRAME_LEN - 1)) ? '0 : clr_addr_q + 1'b1;
        clr_left_q <= clr_left_q - 1'b1;
      end
      if (accept) begin
        if (!kind_i) begin
          dp_q <= '0;
        end else if (drain_ok) begin
          dp_q <= drain_last ? '0 : dp_q + 1'b1;
        end
      end
      if ((state_q == wola_pkg::ST_ACC) && !kind_q) begin
        if (frame_end_q) begin
          fp_q       <= '0;
          rb_q       <= rb_next;
          seen_q     <= 1'b1;
          clr_addr_q <= rb_q;
          clr_left_q <= CW'(CLR_LEN);
        end else begin
          fp_q <= fp_q + 1'b1;
        end
      end
    end
  end

  // Item capture and weighting products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      sample_q    <= sample_i;
      idx_q       <= idx;
      want_out_q  <= kind_i ? 1'b1 : frame_want;
      frame_end_q <= !kind_i && (fp_q == AW'(FRAME_LEN - 1));
      last_q      <= kind_i && drain_last;
    end
    if (state_q == wola_pkg::ST_MUL) begin
      prod_ovl_q <= sample_q * $signed({1'b0, win});
      prod_env_q <= win * win;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == wola_pkg::ST_PUSH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == wola_pkg::ST_PUSH) && out_free) begin
      out_sample_q <= div_rsp.result;
      is_tail_q    <= kind_q;
      tail_last_q  <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign is_tail_o    = is_tail_q;
  assign tail_last_o  = tail_last_q;

  // Checks
  `WOLA_ASSERT_SAME(a_no_rw_overlap, clk_i, rst_ni, st_wr_en, !st_rd_en, "store read and write collide")
  `WOLA_ASSERT_SAME(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `WOLA_ASSERT_NEXT(a_div_takes_req, clk_i, rst_ni, div_req.start, div_rsp.busy, "divider ignored request")
  `WOLA_ASSERT_SAME(a_done_in_div, clk_i, rst_ni, div_rsp.done, state_q == wola_pkg::ST_DIV, "divider result outside wait state")

endmodule

/* dv/weighted_overlap_add_synthesis_tb.sv */
// ----------------------------------------------------------------------------
// weighted_overlap_add_synthesis_tb
// Self-checking bench for the windowed overlap-add synthesis block. A queue
// of frame-sample and drain beats is driven through valid/ready with random
// gaps and stalls on both sides. A predictor kept in step with the accepted
// input beats holds its own window table, overlap and envelope stores. It
// computes every normalised output beat, and each result beat is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module weighted_overlap_add_synthesis_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN = wola_pkg::FRAME_LEN_DEF;
  localparam int unsigned HOP_LEN   = wola_pkg::HOP_LEN_DEF;
  localparam int unsigned ACC_W     = wola_pkg::ACC_W;
  localparam int unsigned SAMPLE_W  = wola_pkg::SAMPLE_W;

  // Beat kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned HOLD_AT_RESULT = 100;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       settle;  // wait for all outputs before offering
  } synth_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       is_tail;
    logic                       tail_last;
  } synth_out_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready_o;
  logic                       kind = KIND_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid_o;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_o;
  logic                       is_tail_o;
  logic                       tail_last_o;

  synth_item_t pending_items[$];
  synth_out_t  pending_outputs[$];

  // Predictor state
  logic        [SAMPLE_W-1:0] root_hann    [FRAME_LEN];
  logic signed [ACC_W-1:0]    overlap_acc  [FRAME_LEN];
  logic        [ACC_W-1:0]    envelope_acc [FRAME_LEN];
  int unsigned ring_base;
  int unsigned frame_pos;
  int unsigned drain_pos;
  logic [1:0]  frames_done;

  // Handshake bookkeeping, refreshed at every rising edge
  logic        in_beat  = 1'b0;
  logic        out_beat = 1'b0;
  int unsigned items_total;
  int unsigned items_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;

  int unsigned tx_wait   = 0;
  bit          tx_steady = 1'b0;
  int unsigned rx_wait   = 0;
  int unsigned rx_hold   = 0;
  bit          rx_steady = 1'b0;

  weighted_overlap_add_synthesis #(
    .FRAME_LEN (FRAME_LEN),
    .HOP_LEN   (HOP_LEN)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind),
    .sample_i     (sample),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_sample_o (out_sample_o),
    .is_tail_o    (is_tail_o),
    .tail_last_o  (tail_last_o)
  );

  // Square-root Hann coefficient: sine by Taylor series in Q30, folded angle
  function automatic logic [SAMPLE_W-1:0] root_hann_coef(int unsigned i);
    longint unsigned fold, ang, term, r;
    longint          acc;
    int unsigned     k;
    fold = (i <= FRAME_LEN / 2) ? i : FRAME_LEN - i;
    ang  = (64'(wola_pkg::PI_Q30) * fold) / FRAME_LEN;
    term = ang;
    acc  = $signed(ang);
    for (k = 1; k <= 5; k++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k[0]) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    r = ($unsigned(acc) + 64'd16384) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return r[SAMPLE_W-1:0];
  endfunction

  // overlap / envelope in Q1.15, halves away from zero, saturated
  function automatic logic signed [SAMPLE_W-1:0] normalise_q15(
    logic signed [ACC_W-1:0] ov,
    logic        [ACC_W-1:0] en
  );
    longint          sov;
    longint unsigned mag, den, q;
    sov = ov;
    den = (en == '0) ? 64'd1 : 64'(en);
    mag = (sov < 0) ? $unsigned(-sov) : $unsigned(sov);
    q   = ((mag << 15) + den / 2) / den;
    if (sov < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      q = 64'd0 - q;
    end else if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the synthesis state by one accepted beat; queue any output
  task automatic advance_synthesis(input logic k, input logic signed [SAMPLE_W-1:0] smp);
    int unsigned idx, tail_len, clr, j;
    logic [SAMPLE_W-1:0] w;
    synth_out_t res;
    tail_len = (FRAME_LEN > HOP_LEN) ? FRAME_LEN - HOP_LEN : 0;
    if (k == KIND_DRAIN) begin
      // nothing pending before the first full frame
      if (frames_done == 0 || tail_len == 0) return;
      if (drain_pos >= tail_len) drain_pos = 0;
      idx = (ring_base + drain_pos) % FRAME_LEN;
      res.out_sample = normalise_q15(overlap_acc[idx], envelope_acc[idx]);
      res.is_tail    = 1'b1;
      res.tail_last  = (drain_pos == tail_len - 1);
      pending_outputs.push_back(res);
      drain_pos = res.tail_last ? 0 : drain_pos + 1;
    end else begin
      drain_pos = 0;
      if (frame_pos >= FRAME_LEN) frame_pos = 0;
      idx = (ring_base + frame_pos) % FRAME_LEN;
      w   = root_hann[frame_pos];
      overlap_acc[idx]  = overlap_acc[idx] + ACC_W'(longint'(smp) * longint'({1'b0, w}));
      envelope_acc[idx] = envelope_acc[idx] + ACC_W'(64'(w) * 64'(w));
      // entry is final once the frame position is below the hop
      if (frame_pos < HOP_LEN && frames_done != 0) begin
        res.out_sample = normalise_q15(overlap_acc[idx], envelope_acc[idx]);
        res.is_tail    = 1'b0;
        res.tail_last  = 1'b0;
        pending_outputs.push_back(res);
      end
      frame_pos++;
      // end of frame: retire the finished entries and move the ring on
      if (frame_pos >= FRAME_LEN) begin
        clr = (HOP_LEN < FRAME_LEN) ? HOP_LEN : FRAME_LEN;
        for (j = 0; j < clr; j++) begin
          overlap_acc[(ring_base + j) % FRAME_LEN]  = '0;
          envelope_acc[(ring_base + j) % FRAME_LEN] = '0;
        end
        ring_base = (ring_base + HOP_LEN % FRAME_LEN) % FRAME_LEN;
        frame_pos = 0;
        if (frames_done < 2) frames_done++;
      end
    end
  endtask

  // Sample values biased towards the extremes and small magnitudes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic k, input logic signed [SAMPLE_W-1:0] s,
                            input logic settle = 1'b0);
    synth_item_t it;
    it.kind   = k;
    it.sample = s;
    it.settle = settle;
    pending_items.push_back(it);
  endtask

  task automatic queue_drains(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) queue_item(KIND_DRAIN, SAMPLE_W'($urandom));
  endtask

  // Frame samples with the odd short burst of drains in between
  task automatic queue_frame_samples(input int unsigned n, input int unsigned burst_max);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      queue_item(KIND_SAMPLE, pick_sample());
      if ($urandom_range(0, 29) == 0) queue_drains($urandom_range(1, burst_max));
    end
  endtask

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitor: check output beats, then predict from the input beat
  always @(posedge clk_i) begin : monitor
    synth_out_t exp_out;
    in_beat  = rst_ni && in_valid && in_ready_o;
    out_beat = rst_ni && out_valid_o && out_ready;
    if (out_beat) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $display("%0t ns: unexpected output beat out_sample=%0d is_tail=%0b tail_last=%0b",
                 $time, out_sample_o, is_tail_o, tail_last_o);
        errors++;
      end else begin
        exp_out = pending_outputs.pop_front();
        if (out_sample_o !== exp_out.out_sample) begin
          $display("%0t ns: out_sample mismatch expected %0d actual %0d",
                   $time, exp_out.out_sample, out_sample_o);
          errors++;
        end
        if (is_tail_o !== exp_out.is_tail) begin
          $display("%0t ns: is_tail mismatch expected %0b actual %0b",
                   $time, exp_out.is_tail, is_tail_o);
          errors++;
        end
        if (tail_last_o !== exp_out.tail_last) begin
          $display("%0t ns: tail_last mismatch expected %0b actual %0b",
                   $time, exp_out.tail_last, tail_last_o);
          errors++;
        end
      end
    end
    if (in_beat) begin
      items_taken++;
      advance_synthesis(kind, sample);
    end
  end

  // Input driver: one beat per queued item, random gap after each
  always @(negedge clk_i) begin : drive_input
    synth_item_t it;
    if (rst_ni && !(in_valid && !in_beat)) begin
      if (in_beat) begin
        tx_wait = tx_steady ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      end
      if (tx_wait != 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].settle && pending_outputs.size() != 0)) begin
        it = pending_items.pop_front();
        kind     <= it.kind;
        sample   <= it.sample;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready: random stall after each beat, one long hold-off
  always @(negedge clk_i) begin : drive_output_ready
    if (rst_ni) begin
      if (out_beat) begin
        rx_wait = rx_steady ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        if (results_seen == HOLD_AT_RESULT) rx_hold = HOLD_CYCLES;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main
    int unsigned i;
    for (i = 0; i < FRAME_LEN; i++) begin
      root_hann[i]    = root_hann_coef(i);
      overlap_acc[i]  = '0;
      envelope_acc[i] = '0;
    end
    ring_base   = 0;
    frame_pos   = 0;
    drain_pos   = 0;
    frames_done = '0;

    // Directed: drains with nothing to read, first-frame extremes, drain
    // inside the first frame
    queue_drains(3);
    queue_item(KIND_SAMPLE, 16'sh7FFF);
    queue_item(KIND_SAMPLE, 16'sh8000);
    queue_item(KIND_SAMPLE, 16'sh0000);
    queue_item(KIND_SAMPLE, 16'shFFFF);
    queue_item(KIND_SAMPLE, 16'sh0001);
    queue_item(KIND_SAMPLE, 16'sh5555);
    queue_item(KIND_SAMPLE, 16'shAAAA);
    queue_item(KIND_SAMPLE, 16'sh4000);
    queue_drains(2);
    queue_item(KIND_SAMPLE, 16'shC000);
    queue_item(KIND_SAMPLE, 16'sh0100);
    queue_item(KIND_SAMPLE, 16'shFFFE);

    // Rest of frame 1, then a full tail drain that wraps past the last
    queue_frame_samples(FRAME_LEN - 11, 3);
    queue_drains(FRAME_LEN - HOP_LEN + 5);
    // Start of frame 2 with mid-frame drains; sender settles part way in
    queue_frame_samples(16, 4);
    queue_item(KIND_SAMPLE, pick_sample(), 1'b1);
    queue_frame_samples(20, 4);
    items_total = pending_items.size();

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(items_taken == items_total && pending_outputs.size() == 0)) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/wola_pkg.sv
hdl/wola_window_rom.sv
hdl/wola_store.sv
hdl/wola_divider.sv
hdl/weighted_overlap_add_synthesis.sv
dv/weighted_overlap_add_synthesis_tb.sv
